>>> rtl/sts_pkg.sv
// ----------------------------------------------------------------------------
// sts_pkg
// Shared types and constants for the sorted table search block: field
// widths, operation and status codes, and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package sts_pkg;

  localparam int DEFAULT_DEPTH = 1024;
  localparam int MODE_W        = 2;
  localparam int IDX_W         = 10;
  localparam int DATA_W        = 64;
  localparam int LEN_CFG_W     = 11;
  localparam int STATUS_W      = 3;

  typedef enum logic [MODE_W-1:0] {
    MODE_WRITE   = 2'd0,
    MODE_LINEAR  = 2'd1,
    MODE_BINARY  = 2'd2,
    MODE_BRACKET = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_BELOW     = 3'd3,
    ST_ABOVE     = 3'd4
  } status_t;

  // Source of the table read address.
  typedef enum logic [1:0] {
    RD_LIN   = 2'd0,
    RD_FIRST = 2'd1,
    RD_LAST  = 2'd2,
    RD_MID   = 2'd3
  } rd_src_t;

  // Source of the index fields of a result.
  typedef enum logic [1:0] {
    RES_ZERO    = 2'd0,
    RES_LIN     = 2'd1,
    RES_MID     = 2'd2,
    RES_BRACKET = 2'd3
  } res_sel_t;

  typedef struct packed {
    logic     capture;
    logic     mem_write;
    logic     rd_en;
    rd_src_t  rd_src;
    logic     lin_adv;
    logic     bin_lo;
    logic     bin_hi;
    logic     res_valid;
    status_t  res_status;
    res_sel_t res_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic len_zero;
    logic lin_end;
    logic lin_hit;
    logic lo_gt_hi;
    logic t_eq;
    logic t_lt;
    logic t_gt;
    logic mid_zero;
    logic bracket;
  } dp_stat_t;

endpackage

>>> rtl/sts_datapath.sv
// ----------------------------------------------------------------------------
// sts_datapath
// Table memory, length register, search counters and bounds, the entry
// comparator and the result register.
// ----------------------------------------------------------------------------
module sts_datapath import sts_pkg::*; #(
  parameter int TABLE_DEPTH = DEFAULT_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [LEN_CFG_W-1:0]        cfg_data,
  input  logic [MODE_W-1:0]           mode,
  input  logic [IDX_W-1:0]            entry_index,
  input  logic signed [DATA_W-1:0]    key_or_data,
  input  dp_cmd_t                     cmd,
  output dp_stat_t                    stat,
  output logic                        done,
  output logic [STATUS_W-1:0]         status,
  output logic [IDX_W-1:0]            lower_index,
  output logic [IDX_W-1:0]            upper_index
);

  localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int LEN_W = AW + 1;

  logic signed [DATA_W-1:0] mem [TABLE_DEPTH];
  logic signed [DATA_W-1:0] rdata;
  logic signed [DATA_W-1:0] key;
  logic [LEN_W-1:0]         len;
  logic                     bracket;
  logic [LEN_W-1:0]         i;
  logic                     pv;
  logic [LEN_W-1:0]         rd_idx;
  logic [LEN_W-1:0]         lo;
  logic [LEN_W-1:0]         hi;
  logic [LEN_W-1:0]         mid;
  logic [LEN_W-1:0]         mid_c;
  logic [LEN_W-1:0]         last;
  logic [AW-1:0]            rd_addr;
  logic                     widx_ok;
  logic [LEN_W-1:0]         br_lower;
  logic [LEN_W-1:0]         br_upper;

  assign last    = len - LEN_W'(1);
  assign mid_c   = lo + ((hi - lo) >> 1);
  assign widx_ok = (32'(entry_index) < TABLE_DEPTH);

  always_comb begin
    case (cmd.rd_src)
      RD_LIN:   rd_addr = AW'(i);
      RD_FIRST: rd_addr = '0;
      RD_LAST:  rd_addr = AW'(last);
      RD_MID:   rd_addr = AW'(mid_c);
      default:  rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_write && widx_ok) begin
      mem[AW'(entry_index)] <= key_or_data;
    end
    if (cmd.rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  // The length is stored already clipped to the table depth.
  always_ff @(posedge clk) begin
    if (rst) begin
      len <= '0;
    end else if (cfg_write) begin
      if (32'(cfg_data) > TABLE_DEPTH) begin
        len <= LEN_W'(TABLE_DEPTH);
      end else begin
        len <= LEN_W'(cfg_data);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= 1'b0;
      i  <= '0;
    end else if (cmd.capture) begin
      pv <= 1'b0;
      i  <= '0;
    end else begin
      pv <= cmd.lin_adv;
      if (cmd.lin_adv) begin
        i <= i + LEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      key     <= key_or_data;
      bracket <= (mode_t'(mode) == MODE_BRACKET);
      lo      <= '0;
      hi      <= last;
    end else begin
      if (cmd.bin_lo) begin
        lo <= mid + LEN_W'(1);
      end
      if (cmd.bin_hi) begin
        hi <= mid - LEN_W'(1);
      end
    end
    if (cmd.lin_adv) begin
      rd_idx <= i;
    end
    if (cmd.rd_en && cmd.rd_src == RD_MID) begin
      mid <= mid_c;
    end
  end

  assign br_lower = (lo == '0) ? '0 : lo - LEN_W'(1);
  assign br_upper = (lo >= len) ? last : lo;

  always_comb begin
    stat.len_zero = (len == '0);
    stat.lin_end  = (i == len);
    stat.lin_hit  = pv && (rdata == key);
    stat.lo_gt_hi = (lo > hi);
    stat.t_eq     = (rdata == key);
    stat.t_lt     = (rdata < key);
    stat.t_gt     = (rdata > key);
    stat.mid_zero = (mid == '0);
    stat.bracket  = bracket;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_valid) begin
      status <= cmd.res_status;
      case (cmd.res_sel)
        RES_LIN: begin
          lower_index <= IDX_W'(rd_idx);
          upper_index <= IDX_W'(rd_idx);
        end
        RES_MID: begin
          lower_index <= IDX_W'(mid);
          upper_index <= IDX_W'(mid);
        end
        RES_BRACKET: begin
          lower_index <= IDX_W'(br_lower);
          upper_index <= IDX_W'(br_upper);
        end
        default: begin
          lower_index <= '0;
          upper_index <= '0;
        end
      endcase
    end
  end

endmodule

>>> rtl/sts_ctrl.sv
// ----------------------------------------------------------------------------
// sts_ctrl
// Sequencer for the table operations: write, linear scan, exact binary
// search and bracketing search with its range checks.
// ----------------------------------------------------------------------------
module sts_ctrl import sts_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [MODE_W-1:0] mode,
  input  dp_stat_t          stat,
  output dp_cmd_t           cmd,
  output logic              busy
);

  typedef enum logic [5:0] {
    S_IDLE      = 6'b000001,
    S_LIN       = 6'b000010,
    S_CHK_FIRST = 6'b000100,
    S_CHK_LAST  = 6'b001000,
    S_BRD       = 6'b010000,
    S_BCMP      = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          if (mode_t'(mode) == MODE_WRITE) begin
            cmd.mem_write  = 1'b1;
            cmd.res_valid  = 1'b1;
            cmd.res_status = ST_OK;
            cmd.res_sel    = RES_ZERO;
          end else if (stat.len_zero) begin
            cmd.res_valid  = 1'b1;
            cmd.res_status = ST_EMPTY;
            cmd.res_sel    = RES_ZERO;
          end else begin
            case (mode_t'(mode))
              MODE_LINEAR: state_next = S_LIN;
              MODE_BINARY: state_next = S_BRD;
              MODE_BRACKET: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_src = RD_FIRST;
                state_next = S_CHK_FIRST;
              end
              default: state_next = S_IDLE;
            endcase
          end
        end
      end
      // One read is issued per cycle while the previous entry is compared.
      // Once the counter reaches the length, the last entry is the one being
      // compared, so a miss there ends the scan.
      S_LIN: begin
        if (stat.lin_hit) begin
          cmd.res_valid  = 1'b1;
          cmd.res_status = ST_OK;
          cmd.res_sel    = RES_LIN;
          state_next     = S_IDLE;
        end else if (!stat.lin_end) begin
          cmd.rd_en   = 1'b1;
          cmd.rd_src  = RD_LIN;
          cmd.lin_adv = 1'b1;
        end else begin
          cmd.res_valid  = 1'b1;
          cmd.res_status = ST_NOT_FOUND;
          cmd.res_sel    = RES_ZERO;
          state_next     = S_IDLE;
        end
      end
      S_CHK_FIRST: begin
        if (stat.t_gt) begin
          cmd.res_valid  = 1'b1;
          cmd.res_status = ST_BELOW;
          cmd.res_sel    = RES_ZERO;
          state_next     = S_IDLE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_src = RD_LAST;
          state_next = S_CHK_LAST;
        end
      end
      S_CHK_LAST: begin
        if (stat.t_lt) begin
          cmd.res_valid  = 1'b1;
          cmd.res_status = ST_ABOVE;
          cmd.res_sel    = RES_ZERO;
          state_next     = S_IDLE;
        end else begin
          state_next = S_BRD;
        end
      end
      S_BRD: begin
        if (stat.lo_gt_hi) begin
          cmd.res_valid = 1'b1;
          if (stat.bracket) begin
            cmd.res_status = ST_OK;
            cmd.res_sel    = RES_BRACKET;
          end else begin
            cmd.res_status = ST_NOT_FOUND;
            cmd.res_sel    = RES_ZERO;
          end
          state_next = S_IDLE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_src = RD_MID;
          state_next = S_BCMP;
        end
      end
      S_BCMP: begin
        if (stat.t_eq) begin
          cmd.res_valid  = 1'b1;
          cmd.res_status = ST_OK;
          cmd.res_sel    = RES_MID;
          state_next     = S_IDLE;
        end else if (stat.t_lt) begin
          cmd.bin_lo = 1'b1;
          state_next = S_BRD;
        end else if (stat.mid_zero) begin
          // The midpoint is already at index zero, so the search stops here.
          cmd.res_valid = 1'b1;
          if (stat.bracket) begin
            cmd.res_status = ST_OK;
            cmd.res_sel    = RES_BRACKET;
          end else begin
            cmd.res_status = ST_NOT_FOUND;
            cmd.res_sel    = RES_ZERO;
          end
          state_next = S_IDLE;
        end else begin
          cmd.bin_hi = 1'b1;
          state_next = S_BRD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

>>> rtl/sorted_table_search.sv
// ----------------------------------------------------------------------------
// sorted_table_search
// Table of signed 64-bit entries with entry writes, linear search, exact
// binary search and bracketing binary search.
// ----------------------------------------------------------------------------
//  Channel   Handshake              Signals
//  config    cfg_write              cfg_data (table_length)
//  command   start, accepted        mode, entry_index, key_or_data
//            when busy is low
//  result    done (one-cycle beat)  status, lower_index, upper_index
//
//  A write, or any search of an empty table, is answered from idle; its result beat
//  follows on the next cycle and the next command may be taken at once. A
//  linear search makes one table read per cycle through the single memory read
//  port. A binary search passes through a read state and a compare state for
//  each halving step, and the bracket search first checks the key against the
//  first and last entries. Reset is synchronous and clears the length and the
//  sequencer; table contents are undefined until written. The result beat
//  cannot be stalled.
// ----------------------------------------------------------------------------
module sorted_table_search import sts_pkg::*; #(
  parameter int TABLE_DEPTH = DEFAULT_DEPTH
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic [LEN_CFG_W-1:0]     cfg_data,
  input  logic                     start,
  output logic                     busy,
  input  logic [MODE_W-1:0]        mode,
  input  logic [IDX_W-1:0]         entry_index,
  input  logic signed [DATA_W-1:0] key_or_data,
  output logic                     done,
  output logic [STATUS_W-1:0]      status,
  output logic [IDX_W-1:0]         lower_index,
  output logic [IDX_W-1:0]         upper_index
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  sts_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .mode  (mode),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  sts_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .mode        (mode),
    .entry_index (entry_index),
    .key_or_data (key_or_data),
    .cmd         (cmd),
    .stat        (stat),
    .done        (done),
    .status      (status),
    .lower_index (lower_index),
    .upper_index (upper_index)
  );

  // The result beat only appears once the sequencer is back to idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result beat while a command is still in progress");

  a_write_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && mode_t'(mode) == MODE_WRITE) |=> (done && !busy))
    else $error("write command did not answer on the next cycle");

  a_search_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && mode_t'(mode) != MODE_WRITE) |=> (done || busy))
    else $error("search command neither answered nor started");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (status <= 3'(ST_ABOVE)))
    else $error("result status code out of range");

endmodule

>>> test/sorted_table_search_tb.sv
// ----------------------------------------------------------------------------
// sorted_table_search_tb
// Self-checking bench for the sorted table search block. A driver feeds
// write, linear, exact binary and bracket commands from a backlog, and a
// monitor checks every result beat against an in-bench prediction of the
// table, the length register and the search rules. A directed part covers
// the value extremes, the empty table, the range checks and the zero-index
// guard. Random rounds then program many short table lengths over mostly
// sorted contents.
// ----------------------------------------------------------------------------
module sorted_table_search_tb import sts_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int     DEPTH        = DEFAULT_DEPTH;
  localparam int     RANDOM_ITEMS = 580;
  localparam int     CYCLE_LIMIT  = 1_000_000;
  localparam int     TAIL_CYCLES  = DEPTH + 100;
  localparam longint MAX_VALUE    = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam longint MIN_VALUE    = longint'(64'h8000_0000_0000_0000);

  typedef struct packed {
    mode_t            op;
    logic [IDX_W-1:0] slot;
    longint           value;
  } command_t;

  typedef struct packed {
    status_t          status;
    logic [IDX_W-1:0] lower;
    logic [IDX_W-1:0] upper;
  } search_result_t;

  logic                     clk;
  logic                     rst         = 1'b1;
  logic                     cfg_write   = 1'b0;
  logic [LEN_CFG_W-1:0]     cfg_data    = '0;
  logic                     start       = 1'b0;
  logic                     busy;
  logic [MODE_W-1:0]        mode        = '0;
  logic [IDX_W-1:0]         entry_index = '0;
  logic signed [DATA_W-1:0] key_or_data = '0;
  logic                     done;
  logic [STATUS_W-1:0]      status;
  logic [IDX_W-1:0]         lower_index;
  logic [IDX_W-1:0]         upper_index;

  // Bench copy of the block state.
  longint               table_copy [DEPTH];
  logic [LEN_CFG_W-1:0] length_copy = '0;

  command_t       command_backlog[$];
  search_result_t expected_outcomes[$];
  command_t       accepted_cmd;
  command_t       next_cmd;
  int             sender_idle_pct = 9;
  int             stimulus_count  = 0;
  int             failure_count   = 0;
  int             cycle_count     = 0;

  sorted_table_search DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .start       (start),
    .busy        (busy),
    .mode        (mode),
    .entry_index (entry_index),
    .key_or_data (key_or_data),
    .done        (done),
    .status      (status),
    .lower_index (lower_index),
    .upper_index (upper_index)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Applies one command to the bench table and returns the result it must give.
  function automatic search_result_t predict_lookup(command_t cmd);
    search_result_t res;
    int             span;
    int             lo;
    int             hi;
    int             mid;
    bit             settled;
    res.status = ST_OK;
    res.lower  = '0;
    res.upper  = '0;
    span = (length_copy > DEPTH) ? DEPTH : int'(length_copy);
    if (cmd.op == MODE_WRITE) begin
      table_copy[cmd.slot] = cmd.value;
      return res;
    end
    if (span == 0) begin
      res.status = ST_EMPTY;
      return res;
    end
    if (cmd.op == MODE_LINEAR) begin
      // Scanning downward leaves the lowest matching index in place.
      res.status = ST_NOT_FOUND;
      for (int i = span - 1; i >= 0; i--) begin
        if (table_copy[i] == cmd.value) begin
          res.status = ST_OK;
          res.lower  = IDX_W'(i);
          res.upper  = IDX_W'(i);
        end
      end
      return res;
    end
    if (cmd.op == MODE_BRACKET) begin
      if (cmd.value < table_copy[0]) begin
        res.status = ST_BELOW;
        return res;
      end
      if (cmd.value > table_copy[span-1]) begin
        res.status = ST_ABOVE;
        return res;
      end
    end
    lo      = 0;
    hi      = span - 1;
    settled = 1'b0;
    while (!settled && lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      if (table_copy[mid] == cmd.value) begin
        res.lower = IDX_W'(mid);
        res.upper = IDX_W'(mid);
        return res;
      end else if (table_copy[mid] < cmd.value) begin
        lo = mid + 1;
      end else if (mid == 0) begin
        settled = 1'b1;
      end else begin
        hi = mid - 1;
      end
    end
    if (cmd.op == MODE_BINARY) begin
      res.status = ST_NOT_FOUND;
      return res;
    end
    res.lower = IDX_W'((lo == 0) ? 0 : lo - 1);
    res.upper = IDX_W'((lo >= span) ? span - 1 : lo);
    return res;
  endfunction

  // Driver: a beat is taken at an edge where start is high and busy is low.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      if (start) begin
        accepted_cmd.op    = mode_t'(mode);
        accepted_cmd.slot  = entry_index;
        accepted_cmd.value = longint'(key_or_data);
        expected_outcomes.push_back(predict_lookup(accepted_cmd));
      end
      if (command_backlog.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
        next_cmd = command_backlog.pop_front();
        start       <= 1'b1;
        mode        <= next_cmd.op;
        entry_index <= next_cmd.slot;
        key_or_data <= next_cmd.value;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: every done beat must match the oldest expected result.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_outcomes.size() == 0) begin
        if (failure_count < 10)
          $display("%0t: result beat with nothing expected:", $realtime,
                   " status %0d lower %0d upper %0d", status, lower_index, upper_index);
        failure_count++;
      end else begin
        if (status !== expected_outcomes[0].status ||
            lower_index !== expected_outcomes[0].lower ||
            upper_index !== expected_outcomes[0].upper) begin
          if (failure_count < 10)
            $display("%0t: result mismatch: expected status %0d lower %0d upper %0d,",
                     $realtime, expected_outcomes[0].status, expected_outcomes[0].lower,
                     expected_outcomes[0].upper,
                     " got status %0d lower %0d upper %0d",
                     status, lower_index, upper_index);
          failure_count++;
        end
        void'(expected_outcomes.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic longint random_word();
    return longint'({$urandom, $urandom});
  endfunction

  task automatic queue_command(mode_t op, int slot, longint value);
    command_t cmd;
    cmd.op    = op;
    cmd.slot  = IDX_W'(slot);
    cmd.value = value;
    command_backlog.push_back(cmd);
    stimulus_count++;
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (command_backlog.size() != 0 || start || expected_outcomes.size() != 0 ||
           busy !== 1'b0);
  endtask

  task automatic program_length(int len);
    wait_idle();
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= LEN_CFG_W'(len);
    @(posedge clk);
    cfg_write <= 1'b0;
    length_copy = LEN_CFG_W'(len);
    @(negedge clk);
  endtask

  // Writes entries 0 .. count-1, non-decreasing when ordered, otherwise scrambled.
  task automatic fill_entries(int count, bit ordered);
    longint level;
    longint stride;
    int     flavor;
    flavor = $urandom_range(0, 3);
    level  = ($urandom_range(0, 4) == 0) ? MIN_VALUE : random_word() >>> $urandom_range(0, 20);
    for (int i = 0; i < count; i++) begin
      if (!ordered) begin
        // Small values give duplicates, so the linear search must pick the first.
        level = (flavor == 0) ? random_word() : longint'($urandom_range(0, 5)) - 2;
      end else if (i > 0) begin
        case (flavor)
          0: begin
            stride = $urandom_range(0, 2);
          end
          1: begin
            stride = $urandom_range(0, 100000);
          end
          default: begin
            stride = (random_word() & MAX_VALUE) >> $urandom_range(4, 62);
          end
        endcase
        level = (level > MAX_VALUE - stride) ? MAX_VALUE : level + stride;
      end
      queue_command(MODE_WRITE, i, level);
    end
  endtask

  // Searches with keys mostly taken from or next to the table, plus stray writes.
  task automatic queue_searches(int count);
    int     span;
    int     pick;
    int     roll;
    longint key;
    span = (length_copy > DEPTH) ? DEPTH : int'(length_copy);
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      pick = (span > 0) ? $urandom_range(0, span - 1) : 0;
      if (roll < 8) begin
        queue_command(MODE_WRITE, $urandom_range(0, DEPTH - 1), random_word());
      end else begin
        if (span == 0 || roll >= 85)
          key = random_word();
        else if (roll < 50)
          key = table_copy[pick];
        else if (roll < 62)
          key = table_copy[pick] + 1;
        else if (roll < 74)
          key = table_copy[pick] - 1;
        else
          key = roll[0] ? MAX_VALUE : MIN_VALUE;
        queue_command(mode_t'($urandom_range(1, 3)), $urandom_range(0, DEPTH - 1), key);
      end
    end
  endtask

  initial begin
    longint ladder [8];
    int     span;
    int     roll;
    ladder = '{MIN_VALUE + 1, -1000, -1, 0, 5, 77, 1000, MAX_VALUE - 1};

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    program_length(0);

    // Empty table in every search mode.
    queue_command(MODE_LINEAR, 0, 0);
    queue_command(MODE_BINARY, DEPTH - 1, MAX_VALUE);
    queue_command(MODE_BRACKET, 0, MIN_VALUE);
    for (int i = 0; i < 8; i++)
      queue_command(MODE_WRITE, i, ladder[i]);
    queue_command(MODE_WRITE, DEPTH - 1, MIN_VALUE);
    program_length(8);
    queue_command(MODE_LINEAR, 0, 5);
    queue_command(MODE_LINEAR, 0, 6);
    queue_command(MODE_BINARY, 0, MIN_VALUE + 1);
    queue_command(MODE_BINARY, 0, MAX_VALUE - 1);
    // Key under the first entry: the search stops at the zero-index guard.
    queue_command(MODE_BINARY, 0, MIN_VALUE);
    queue_command(MODE_BINARY, 0, 6);
    queue_command(MODE_BRACKET, 0, MIN_VALUE);
    queue_command(MODE_BRACKET, 0, MAX_VALUE);
    queue_command(MODE_BRACKET, 0, 3);
    queue_command(MODE_BRACKET, 0, 0);
    queue_command(MODE_BRACKET, 0, MAX_VALUE - 1);
    program_length(1);
    queue_command(MODE_BRACKET, 0, MIN_VALUE + 1);
    queue_command(MODE_BINARY, 0, 0);

    stimulus_count = 0;
    while (stimulus_count < RANDOM_ITEMS) begin
      sender_idle_pct = (stimulus_count < RANDOM_ITEMS / 3) ? 9 :
                        (stimulus_count < 2 * RANDOM_ITEMS / 3) ? 47 : 0;
      roll = $urandom_range(0, 99);
      if (roll < 6)
        span = 0;
      else if (roll < 16)
        span = 1;
      else if (roll < 85)
        span = $urandom_range(2, 16);
      else
        span = $urandom_range(17, 64);
      fill_entries(span, $urandom_range(0, 99) < 85);
      program_length(span);
      queue_searches($urandom_range(4, 12));
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (failure_count == 0 && expected_outcomes.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/sts_pkg.sv
rtl/sts_datapath.sv
rtl/sts_ctrl.sv
rtl/sorted_table_search.sv
test/sorted_table_search_tb.sv
